// ===== design/icst_pkg.sv =====
// Shared types, constants and token-plan functions for the currency speech token block.
// Used by icst_front, icst_queue, icst_back and indian_currency_speech_tokens.
`timescale 1ns / 1ps
package icst_pkg;

  // Amount and decimal conversion
  localparam int AMT_W   = 31;
  localparam int NDIG    = 10;
  localparam int DIG_W   = 4 * NDIG;
  localparam int CNT_W   = 4;
  localparam int RECIP_W = 32;
  localparam int PROD_W  = AMT_W + RECIP_W;
  localparam int SHIFT   = 35;
  localparam int Q_W     = PROD_W - SHIFT;
  localparam logic [RECIP_W-1:0] RECIP = 32'hCCCC_CCCD;

  // Token slots: one bit per possible token of an amount, in speaking order
  localparam int SLOTS  = 18;
  localparam int SLOT_W = 5;
  localparam int QDEPTH = 2;

  localparam logic [SLOT_W-1:0] S_PAY       = 5'd0;
  localparam logic [SLOT_W-1:0] S_CRORE_B   = 5'd1;
  localparam logic [SLOT_W-1:0] S_CRORE_U   = 5'd2;
  localparam logic [SLOT_W-1:0] S_LAKH_A    = 5'd3;
  localparam logic [SLOT_W-1:0] S_LAKH_B    = 5'd4;
  localparam logic [SLOT_W-1:0] S_LAKH_U    = 5'd5;
  localparam logic [SLOT_W-1:0] S_THOU_A    = 5'd6;
  localparam logic [SLOT_W-1:0] S_THOU_B    = 5'd7;
  localparam logic [SLOT_W-1:0] S_THOU_U    = 5'd8;
  localparam logic [SLOT_W-1:0] S_HUND_N    = 5'd9;
  localparam logic [SLOT_W-1:0] S_HUND_U    = 5'd10;
  localparam logic [SLOT_W-1:0] S_REST_A    = 5'd11;
  localparam logic [SLOT_W-1:0] S_REST_B    = 5'd12;
  localparam logic [SLOT_W-1:0] S_RUPEES    = 5'd13;
  localparam logic [SLOT_W-1:0] S_AND       = 5'd14;
  localparam logic [SLOT_W-1:0] S_PAISE_A   = 5'd15;
  localparam logic [SLOT_W-1:0] S_PAISE_B   = 5'd16;
  localparam logic [SLOT_W-1:0] S_PAISE_TOK = 5'd17;

  // Token kinds
  localparam logic [2:0] KIND_PAY    = 3'd0;
  localparam logic [2:0] KIND_NUM    = 3'd1;
  localparam logic [2:0] KIND_UNIT   = 3'd2;
  localparam logic [2:0] KIND_RUPEES = 3'd3;
  localparam logic [2:0] KIND_AND    = 3'd4;
  localparam logic [2:0] KIND_PAISE  = 3'd5;

  // Unit word values
  localparam logic [6:0] UNIT_HUND  = 7'd0;
  localparam logic [6:0] UNIT_THOU  = 7'd1;
  localparam logic [6:0] UNIT_LAKH  = 7'd2;
  localparam logic [6:0] UNIT_CRORE = 7'd3;

  typedef logic [DIG_W-1:0] digits_t;
  typedef logic [SLOTS-1:0] mask_t;

  typedef struct packed {
    digits_t digits;
    mask_t   mask;
  } plan_t;

  // Decimal digit k, counted from the paise units digit
  function automatic logic [3:0] dig(input digits_t d, input int k);
    dig = d[4*k +: 4];
  endfunction

  function automatic logic [6:0] tens_val(input logic [3:0] t);
    tens_val = ({3'b000, t} << 3) + ({3'b000, t} << 1);
  endfunction

  // First word of a two-digit group: the tens word, only above twenty
  function automatic logic word_a(input logic [3:0] t, input logic [3:0] u);
    word_a = (t > 4'd2) || ((t == 4'd2) && (u != 4'd0));
  endfunction

  // Second word: the whole group up to twenty, else the units digit
  function automatic logic word_b(input logic [3:0] t, input logic [3:0] u);
    word_b = (u != 4'd0) || (t == 4'd1) || (t == 4'd2);
  endfunction

  function automatic logic [6:0] word_b_val(input logic [3:0] t, input logic [3:0] u);
    if ((t < 4'd2) || ((t == 4'd2) && (u == 4'd0))) begin
      word_b_val = tens_val(t) + {3'b000, u};
    end else begin
      word_b_val = {3'b000, u};
    end
  endfunction

  // Which tokens an amount speaks
  function automatic mask_t build_mask(input digits_t d);
    logic crore, lakh, thou, rupees, paise;
    mask_t m;
    crore  = dig(d, 9) != 4'd0;
    lakh   = (dig(d, 8) != 4'd0) || (dig(d, 7) != 4'd0);
    thou   = (dig(d, 6) != 4'd0) || (dig(d, 5) != 4'd0);
    rupees = d[DIG_W-1:8] != '0;
    paise  = d[7:0] != 8'd0;
    m = '0;
    m[S_PAY]       = 1'b1;
    m[S_CRORE_B]   = crore;
    m[S_CRORE_U]   = crore;
    m[S_LAKH_A]    = word_a(dig(d, 8), dig(d, 7));
    m[S_LAKH_B]    = word_b(dig(d, 8), dig(d, 7));
    m[S_LAKH_U]    = lakh;
    m[S_THOU_A]    = word_a(dig(d, 6), dig(d, 5));
    m[S_THOU_B]    = word_b(dig(d, 6), dig(d, 5));
    m[S_THOU_U]    = thou;
    m[S_HUND_N]    = dig(d, 4) != 4'd0;
    m[S_HUND_U]    = dig(d, 4) != 4'd0;
    m[S_REST_A]    = word_a(dig(d, 3), dig(d, 2));
    m[S_REST_B]    = word_b(dig(d, 3), dig(d, 2));
    m[S_RUPEES]    = rupees;
    m[S_AND]       = rupees && paise;
    m[S_PAISE_A]   = word_a(dig(d, 1), dig(d, 0));
    m[S_PAISE_B]   = word_b(dig(d, 1), dig(d, 0));
    m[S_PAISE_TOK] = paise;
    build_mask = m;
  endfunction

  function automatic logic [2:0] slot_kind(input logic [SLOT_W-1:0] s);
    unique case (s)
      S_PAY:                                 slot_kind = KIND_PAY;
      S_CRORE_U, S_LAKH_U, S_THOU_U, S_HUND_U: slot_kind = KIND_UNIT;
      S_RUPEES:                              slot_kind = KIND_RUPEES;
      S_AND:                                 slot_kind = KIND_AND;
      S_PAISE_TOK:                           slot_kind = KIND_PAISE;
      default:                               slot_kind = KIND_NUM;
    endcase
  endfunction

  function automatic logic [6:0] slot_value(input logic [SLOT_W-1:0] s, input digits_t d);
    unique case (s)
      S_CRORE_B: slot_value = word_b_val(4'd0, dig(d, 9));
      S_CRORE_U: slot_value = UNIT_CRORE;
      S_LAKH_A:  slot_value = tens_val(dig(d, 8));
      S_LAKH_B:  slot_value = word_b_val(dig(d, 8), dig(d, 7));
      S_LAKH_U:  slot_value = UNIT_LAKH;
      S_THOU_A:  slot_value = tens_val(dig(d, 6));
      S_THOU_B:  slot_value = word_b_val(dig(d, 6), dig(d, 5));
      S_THOU_U:  slot_value = UNIT_THOU;
      S_HUND_N:  slot_value = {3'b000, dig(d, 4)};
      S_HUND_U:  slot_value = UNIT_HUND;
      S_REST_A:  slot_value = tens_val(dig(d, 3));
      S_REST_B:  slot_value = word_b_val(dig(d, 3), dig(d, 2));
      S_PAISE_A: slot_value = tens_val(dig(d, 1));
      S_PAISE_B: slot_value = word_b_val(dig(d, 1), dig(d, 0));
      default:   slot_value = 7'd0;
    endcase
  endfunction

endpackage

// ===== design/icst_front.sv =====
// Front end: accepts an amount, splits it into ten decimal digits and builds the token plan.
// Depends on icst_pkg.
`timescale 1ns / 1ps
module icst_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [icst_pkg::AMT_W-1:0]      amount_paise,
  output logic                            busy,
  input  logic                            full,
  output logic                            push,
  output icst_pkg::plan_t                 push_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]                      state, state_next;
  logic [icst_pkg::CNT_W-1:0]      cnt, cnt_next;
  logic [icst_pkg::AMT_W-1:0]      x;
  logic [icst_pkg::PROD_W-1:0]     prod;
  icst_pkg::digits_t               digits;
  logic [icst_pkg::Q_W-1:0]        q;
  logic [icst_pkg::AMT_W-1:0]      mult_in;
  logic [3:0]                      ten_q;
  logic [3:0]                      digit;
  logic                            accept;
  logic                            conv;

  // Quotient by ten from the registered reciprocal product; remainder from low bits
  assign q       = prod[icst_pkg::PROD_W-1:icst_pkg::SHIFT];
  assign ten_q   = {q[0], 3'b000} + {q[2:0], 1'b0};
  assign digit   = x[3:0] - ten_q;
  assign conv    = (state == ST_CONV);
  assign mult_in = conv ? icst_pkg::AMT_W'(q) : amount_paise;

  assign busy   = conv || ((state == ST_PUSH) && full);
  assign accept = start && !busy;
  assign push   = (state == ST_PUSH) && !full;

  assign push_data.digits = digits;
  assign push_data.mask   = icst_pkg::build_mask(digits);

  // Sequence load, ten digit steps, then hand off to the queue
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CONV;
          cnt_next   = '0;
        end
      end
      ST_CONV: begin
        if (cnt == icst_pkg::CNT_W'(icst_pkg::NDIG - 1)) begin
          state_next = ST_PUSH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_PUSH: begin
        if (push) begin
          state_next = accept ? ST_CONV : ST_IDLE;
          cnt_next   = '0;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Advance the divide-by-ten datapath
  always_ff @(posedge clk) begin
    if (accept || conv) begin
      prod <= icst_pkg::PROD_W'(mult_in) * icst_pkg::PROD_W'(icst_pkg::RECIP);
    end
    if (accept) begin
      x <= amount_paise;
    end else if (conv) begin
      x      <= icst_pkg::AMT_W'(q);
      digits <= {digit, digits[icst_pkg::DIG_W-1:4]};
    end
  end

endmodule

// ===== design/icst_queue.sv =====
// Two-entry queue of token plans between the front end and the token sequencer.
// Depends on icst_pkg.
`timescale 1ns / 1ps
module icst_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  icst_pkg::plan_t push_data,
  input  logic            pop,
  output icst_pkg::plan_t head,
  output logic            full,
  output logic            empty
);

  logic [$clog2(icst_pkg::QDEPTH)-1:0] wr_ptr, rd_ptr;
  logic [$clog2(icst_pkg::QDEPTH+1)-1:0] count;
  icst_pkg::plan_t entries [icst_pkg::QDEPTH];

  assign full  = (count == ($clog2(icst_pkg::QDEPTH+1))'(icst_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the written plan
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/icst_back.sv =====
// Back end: walks the token plan at the queue head and emits one token per cycle.
// Depends on icst_pkg.
`timescale 1ns / 1ps
module icst_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  icst_pkg::plan_t head,
  output logic            pop,
  output logic            strobe,
  output logic [2:0]      token_kind,
  output logic [6:0]      token_value,
  output logic            last_token
);

  icst_pkg::mask_t                 remaining, remaining_next;
  icst_pkg::digits_t               digits, digits_next;
  icst_pkg::mask_t                 lowest;
  icst_pkg::mask_t                 rest;
  logic [icst_pkg::SLOT_W-1:0]     idx;
  logic                            emit;

  // Pick the earliest token still to speak
  always_comb begin
    idx = '0;
    for (int i = icst_pkg::SLOTS - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        idx = icst_pkg::SLOT_W'(i);
      end
    end
  end

  assign lowest = remaining & (~remaining + 1'b1);
  assign rest   = remaining & ~lowest;
  assign emit   = (remaining != '0);
  assign pop    = (rest == '0) && !empty;

  assign remaining_next = pop ? head.mask : rest;
  assign digits_next    = pop ? head.digits : digits;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining  <= '0;
      strobe     <= 1'b0;
      last_token <= 1'b0;
    end else begin
      remaining  <= remaining_next;
      strobe     <= emit;
      last_token <= emit && (rest == '0);
    end
  end

  // Hold the digits of the current amount and register the token fields
  always_ff @(posedge clk) begin
    digits      <= digits_next;
    token_kind  <= icst_pkg::slot_kind(idx);
    token_value <= icst_pkg::slot_value(idx, digits);
  end

  a_last_has_strobe: assert property (@(posedge clk) disable iff (rst)
    last_token |-> strobe)
    else $error("last_token without strobe");

  a_tokens_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_token) |=> strobe)
    else $error("gap inside an amount's token run");

  a_pay_opens_amount: assert property (@(posedge clk) disable iff (rst)
    (strobe && (token_kind == icst_pkg::KIND_PAY)) |-> ($past(!strobe) || $past(last_token)))
    else $error("pay token in the middle of an amount");

  a_amount_opens_with_pay: assert property (@(posedge clk) disable iff (rst)
    (strobe && ($past(!strobe) || $past(last_token))) |-> (token_kind == icst_pkg::KIND_PAY))
    else $error("amount does not open with pay");

endmodule

// ===== design/indian_currency_speech_tokens.sv =====
// Top level of the currency speech token block: front end, plan queue, token sequencer.
// Depends on icst_pkg, icst_front, icst_queue and icst_back.
//
// Pulse start with an amount in paise while busy is low; the block answers with 1 to 18
// tokens, one per cycle on strobe, with last_token on the final one. The receiver cannot
// stall. The front end loads the amount, then takes one decimal digit per cycle through a
// reciprocal multiply, and can take a new amount in the cycle it hands the finished plan
// to a two-entry queue. The sequencer emits one token per cycle with no gap between
// amounts while the next plan is already queued, so the sustained pace is set by the
// slower of the front end's digit conversion and the token run of each amount.
`timescale 1ns / 1ps
module indian_currency_speech_tokens (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [icst_pkg::AMT_W-1:0] amount_paise,
  output logic                       strobe,
  output logic [2:0]                 token_kind,
  output logic [6:0]                 token_value,
  output logic                       last_token
);

  icst_pkg::plan_t push_data;
  icst_pkg::plan_t head;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  icst_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .amount_paise (amount_paise),
    .busy         (busy),
    .full         (full),
    .push         (push),
    .push_data    (push_data)
  );

  icst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  icst_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .head        (head),
    .pop         (pop),
    .strobe      (strobe),
    .token_kind  (token_kind),
    .token_value (token_value),
    .last_token  (last_token)
  );

endmodule
